[sv/kd_tree_median_build_macros.svh]
// Assertion macros for the kd-tree build block.
// KDMB_ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// KDMB_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef KD_TREE_MEDIAN_BUILD_MACROS_SVH
`define KD_TREE_MEDIAN_BUILD_MACROS_SVH
`ifndef SYNTH
`define KDMB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kd-tree build: same-cycle check failed");
`define KDMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kd-tree build: next-cycle check failed");
`else
`define KDMB_ASSERT_NOW(label, clk, rst, ante, cons)
`define KDMB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/kdmb_pkg.sv]
package kdmb_pkg;

   localparam int IN_W        = 32;
   localparam int SLOT_W      = 6;
   localparam int ID_W        = 6;
   localparam int AXIS_W      = 2;
   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = 5;

   // datapath operations, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_ROOT,
      OP_POP,
      OP_PIVA,
      OP_PIVB,
      OP_PIVC,
      OP_SCAN,
      OP_KEY,
      OP_CMP,
      OP_WR2,
      OP_FINA,
      OP_FINB,
      OP_FINC,
      OP_NODE,
      OP_EMIT_INIT,
      OP_EMRD,
      OP_EMIT_ADV
   } dp_op_type;

   typedef enum logic [4:0] {
      S_LOAD,
      S_INIT,
      S_ROOT,
      S_NEXT,
      S_RANGE,
      S_SEL,
      S_PIVB,
      S_PIVC,
      S_SCAN,
      S_KEY,
      S_CMP,
      S_WR2,
      S_FINB,
      S_FINC,
      S_NODE,
      S_EMRD,
      S_EMIT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic stack_empty;
      logic range_empty;
      logic sel_small;
      logic scan_done;
      logic is_less;
      logic p_eq_mid;
      logic emit_last;
   } status_type;

endpackage

[sv/kdmb_ifs.sv]
interface kdmb_req_if import kdmb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  x_coord;
   logic signed [IN_W-1:0]  y_coord;
   logic signed [IN_W-1:0]  z_coord;
   logic                    final_point;

   modport source (output valid, x_coord, y_coord, z_coord, final_point, input ready);
   modport sink   (input valid, x_coord, y_coord, z_coord, final_point, output ready);
endinterface

interface kdmb_rsp_if import kdmb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic [ID_W-1:0]   point_id;
   logic [AXIS_W-1:0] split_axis;
   logic              end_of_tree;

   modport source (output valid, slot, point_id, split_axis, end_of_tree, input ready);
   modport sink   (input valid, slot, point_id, split_axis, end_of_tree, output ready);
endinterface

[sv/kdmb_ctrl.sv]
module kdmb_ctrl import kdmb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_final,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (req_final) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.op = OP_INIT;
            if (status.init_last) state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.op   = OP_ROOT;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (status.stack_empty) begin
               cmd.op   = OP_EMIT_INIT;
               state_in = S_EMRD;
            end else begin
               cmd.op   = OP_POP;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            state_in = status.range_empty ? S_NEXT : S_SEL;
         end
         S_SEL: begin
            if (status.sel_small) begin
               state_in = S_NODE;
            end else begin
               cmd.op   = OP_PIVA;
               state_in = S_PIVB;
            end
         end
         S_PIVB: begin
            cmd.op   = OP_PIVB;
            state_in = S_PIVC;
         end
         S_PIVC: begin
            cmd.op   = OP_PIVC;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_done) begin
               cmd.op   = OP_FINA;
               state_in = S_FINB;
            end else begin
               cmd.op   = OP_SCAN;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            cmd.op   = OP_KEY;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op   = OP_CMP;
            state_in = status.is_less ? S_WR2 : S_SCAN;
         end
         S_WR2: begin
            cmd.op   = OP_WR2;
            state_in = S_SCAN;
         end
         S_FINB: begin
            cmd.op   = OP_FINB;
            state_in = S_FINC;
         end
         S_FINC: begin
            cmd.op   = OP_FINC;
            state_in = status.p_eq_mid ? S_NODE : S_SEL;
         end
         S_NODE: begin
            cmd.op   = OP_NODE;
            state_in = S_NEXT;
         end
         S_EMRD: begin
            cmd.op   = OP_EMRD;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.op   = OP_EMIT_ADV;
               state_in = status.emit_last ? S_LOAD : S_EMRD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

[sv/kdmb_dpath.sv]
module kdmb_dpath import kdmb_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 32,
   parameter int NUM_AXES   = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic signed [IN_W-1:0] x_coord,
   input  logic signed [IN_W-1:0] y_coord,
   input  logic signed [IN_W-1:0] z_coord,
   output status_type             status,
   output logic [SLOT_W-1:0]      slot,
   output logic [ID_W-1:0]        point_id,
   output logic [AXIS_W-1:0]      split_axis,
   output logic                   end_of_tree
);

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   // memories
   logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] z_mem [MAX_POINTS];
   logic [IW-1:0]         ord_mem [MAX_POINTS];
   logic [AXIS_W-1:0]     axis_mem [MAX_POINTS];

   // range stack
   logic [CW-1:0]     stk_lo_ff [STACK_DEPTH];
   logic [CW-1:0]     stk_hi_ff [STACK_DEPTH];
   logic [AXIS_W-1:0] stk_ax_ff [STACK_DEPTH];

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [CW-1:0]     ctr_ff, ctr_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     store_ff, store_in;
   logic [CW-1:0]     sel_lo_ff, sel_lo_in;
   logic [CW-1:0]     sel_hi_ff, sel_hi_in;
   logic [CW-1:0]     rng_lo_ff, rng_lo_in;
   logic [CW-1:0]     rng_hi_ff, rng_hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic [COORD_BITS-1:0] pval_ff;
   logic [IW-1:0]     rd0_ff, rd1_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [AXIS_W-1:0] axrd_ff;

   logic              ord_we, ord_re, crd_re;
   logic [IW-1:0]     ord_wa, ord_wd, ord_ra0, ord_ra1;
   logic [CW-1:0]     piv, hm1, top_lo, top_hi;
   logic [SP_W-1:0]   top;
   logic [AXIS_W-1:0] next_axis;
   logic [COORD_BITS-1:0] cur_key;
   logic              push_r, push_l;
   logic signed [COORD_BITS-1:0] ext_x, ext_y, ext_z;

   assign piv    = sel_lo_ff + ((sel_hi_ff - sel_lo_ff) >> 1);
   assign hm1    = sel_hi_ff - CW'(1);
   assign top    = sp_ff - SP_W'(1);
   assign top_lo = stk_lo_ff[top[SP_W-2:0]];
   assign top_hi = stk_hi_ff[top[SP_W-2:0]];
   assign next_axis = (axis_ff == AXIS_W'(NUM_AXES - 1)) ? '0 : axis_ff + AXIS_W'(1);
   assign push_r = (mid_ff + CW'(1)) < rng_hi_ff;
   assign push_l = rng_lo_ff < mid_ff;

   // order-preserving key: wrap to COORD_BITS, flip sign bit
   assign ext_x = COORD_BITS'(x_coord);
   assign ext_y = COORD_BITS'(y_coord);
   assign ext_z = COORD_BITS'(z_coord);

   always_comb begin
      case (axis_ff)
         2'd0:    cur_key = cx_ff;
         2'd1:    cur_key = cy_ff;
         default: cur_key = cz_ff;
      endcase
   end

   always_comb begin
      status.init_last   = ctr_ff == cnt_ff - CW'(1);
      status.stack_empty = sp_ff == '0;
      status.range_empty = rng_lo_ff >= rng_hi_ff;
      status.sel_small   = (sel_hi_ff - sel_lo_ff) <= CW'(1);
      status.scan_done   = k_ff >= hm1;
      status.is_less     = cur_key < pval_ff;
      status.p_eq_mid    = store_ff == mid_ff;
      status.emit_last   = ctr_ff == cnt_ff - CW'(1);
   end

   always_comb begin
      cnt_in    = cnt_ff;
      sp_in     = sp_ff;
      ctr_in    = ctr_ff;
      k_in      = k_ff;
      store_in  = store_ff;
      sel_lo_in = sel_lo_ff;
      sel_hi_in = sel_hi_ff;
      rng_lo_in = rng_lo_ff;
      rng_hi_in = rng_hi_ff;
      mid_in    = mid_ff;
      axis_in   = axis_ff;
      ord_we    = 1'b0;
      ord_wa    = '0;
      ord_wd    = '0;
      ord_re    = 1'b0;
      ord_ra0   = '0;
      ord_ra1   = '0;
      crd_re    = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            ctr_in = '0;
            if (cnt_ff < CW'(MAX_POINTS)) cnt_in = cnt_ff + CW'(1);
         end
         OP_INIT: begin
            ord_we = 1'b1;
            ord_wa = ctr_ff[IW-1:0];
            ord_wd = ctr_ff[IW-1:0];
            ctr_in = ctr_ff + CW'(1);
         end
         OP_ROOT: begin
            sp_in = SP_W'(1);
         end
         OP_POP: begin
            sp_in     = top;
            rng_lo_in = top_lo;
            rng_hi_in = top_hi;
            sel_lo_in = top_lo;
            sel_hi_in = top_hi;
            mid_in    = top_lo + ((top_hi - top_lo) >> 1);
            axis_in   = stk_ax_ff[top[SP_W-2:0]];
         end
         OP_PIVA: begin
            ord_re  = 1'b1;
            ord_ra0 = piv[IW-1:0];
            ord_ra1 = hm1[IW-1:0];
         end
         OP_PIVB: begin
            ord_we = 1'b1;
            ord_wa = piv[IW-1:0];
            ord_wd = rd1_ff;
            crd_re = 1'b1;
         end
         OP_PIVC: begin
            ord_we   = 1'b1;
            ord_wa   = hm1[IW-1:0];
            ord_wd   = rd0_ff;
            k_in     = sel_lo_ff;
            store_in = sel_lo_ff;
         end
         OP_SCAN, OP_FINA: begin
            ord_re  = 1'b1;
            ord_ra0 = (cmd.op == OP_SCAN) ? k_ff[IW-1:0] : store_ff[IW-1:0];
            ord_ra1 = (cmd.op == OP_SCAN) ? store_ff[IW-1:0] : hm1[IW-1:0];
         end
         OP_KEY: begin
            crd_re = 1'b1;
         end
         OP_CMP: begin
            if (status.is_less) begin
               ord_we = 1'b1;
               ord_wa = k_ff[IW-1:0];
               ord_wd = rd1_ff;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         OP_WR2: begin
            ord_we   = 1'b1;
            ord_wa   = store_ff[IW-1:0];
            ord_wd   = rd0_ff;
            store_in = store_ff + CW'(1);
            k_in     = k_ff + CW'(1);
         end
         OP_FINB: begin
            ord_we = 1'b1;
            ord_wa = store_ff[IW-1:0];
            ord_wd = rd1_ff;
         end
         OP_FINC: begin
            ord_we = 1'b1;
            ord_wa = hm1[IW-1:0];
            ord_wd = rd0_ff;
            if (mid_ff < store_ff) begin
               sel_hi_in = store_ff;
            end else begin
               sel_lo_in = store_ff + CW'(1);
            end
         end
         OP_NODE: begin
            sp_in = sp_ff + SP_W'(push_r) + SP_W'(push_l);
         end
         OP_EMIT_INIT: begin
            ctr_in = '0;
         end
         OP_EMRD: begin
            ord_re  = 1'b1;
            ord_ra0 = ctr_ff[IW-1:0];
            ord_ra1 = ctr_ff[IW-1:0];
         end
         OP_EMIT_ADV: begin
            ctr_in = ctr_ff + CW'(1);
            if (status.emit_last) cnt_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sp_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sp_ff  <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff    <= ctr_in;
      k_ff      <= k_in;
      store_ff  <= store_in;
      sel_lo_ff <= sel_lo_in;
      sel_hi_ff <= sel_hi_in;
      rng_lo_ff <= rng_lo_in;
      rng_hi_ff <= rng_hi_in;
      mid_ff    <= mid_in;
      axis_ff   <= axis_in;
      if (cmd.op == OP_PIVC) pval_ff <= cur_key;
   end

   // stack pushes: right half first, left half on top
   always_ff @(posedge clock) begin
      if (cmd.op == OP_ROOT) begin
         stk_lo_ff[0] <= '0;
         stk_hi_ff[0] <= cnt_ff;
         stk_ax_ff[0] <= '0;
      end else if (cmd.op == OP_NODE) begin
         if (push_r) begin
            stk_lo_ff[sp_ff[SP_W-2:0]] <= mid_ff + CW'(1);
            stk_hi_ff[sp_ff[SP_W-2:0]] <= rng_hi_ff;
            stk_ax_ff[sp_ff[SP_W-2:0]] <= next_axis;
         end
         if (push_l) begin
            stk_lo_ff[sp_in[SP_W-2:0] - (SP_W-1)'(1)] <= rng_lo_ff;
            stk_hi_ff[sp_in[SP_W-2:0] - (SP_W-1)'(1)] <= mid_ff;
            stk_ax_ff[sp_in[SP_W-2:0] - (SP_W-1)'(1)] <= next_axis;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && cnt_ff < CW'(MAX_POINTS)) begin
         x_mem[cnt_ff[IW-1:0]] <= {~ext_x[COORD_BITS-1], ext_x[COORD_BITS-2:0]};
         y_mem[cnt_ff[IW-1:0]] <= {~ext_y[COORD_BITS-1], ext_y[COORD_BITS-2:0]};
         z_mem[cnt_ff[IW-1:0]] <= {~ext_z[COORD_BITS-1], ext_z[COORD_BITS-2:0]};
      end
      if (crd_re) begin
         cx_ff <= x_mem[rd0_ff];
         cy_ff <= y_mem[rd0_ff];
         cz_ff <= z_mem[rd0_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_wa] <= ord_wd;
      if (ord_re) begin
         rd0_ff <= ord_mem[ord_ra0];
         rd1_ff <= ord_mem[ord_ra1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_NODE) axis_mem[mid_ff[IW-1:0]] <= axis_ff;
      if (cmd.op == OP_EMRD) axrd_ff <= axis_mem[ctr_ff[IW-1:0]];
   end

   assign slot        = SLOT_W'(ctr_ff);
   assign point_id    = ID_W'(rd0_ff);
   assign split_axis  = axrd_ff;
   assign end_of_tree = status.emit_last;

endmodule

[sv/kd_tree_median_build.sv]
// channel | dir | handshake          | payload
// --------+-----+--------------------+---------------------------------------------
// req     | in  | req_port valid/rdy | x_coord, y_coord, z_coord, final_point
// rsp     | out | rsp_port valid/rdy | slot, point_id, split_axis, end_of_tree
//
// Loading accepts one item per cycle; the item with final_point set starts the build.
// Build: the order array is seeded first, then each quickselect compare steps through
// order read, key read, compare and an optional swap write on the single-write order
// memory; results then leave one at a time, each read out before it is offered.
// Reset (synchronous) clears the point count, stack pointer and controller state.
// req is not ready during build or emit; a stalled rsp holds its item.
`include "kd_tree_median_build_macros.svh"

module kd_tree_median_build import kdmb_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 32,
   parameter int NUM_AXES   = 3
) (
   input logic         clock,
   input logic         reset,
   kdmb_req_if.sink    req_port,
   kdmb_rsp_if.source  rsp_port
);

   cmd_type    cmd;
   status_type status;

   // sequencer: load, build, emit
   kdmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_final (req_port.final_point),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // point stores, order memory, range stack and compare
   kdmb_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .NUM_AXES   (NUM_AXES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .x_coord     (req_port.x_coord),
      .y_coord     (req_port.y_coord),
      .z_coord     (req_port.z_coord),
      .status      (status),
      .slot        (rsp_port.slot),
      .point_id    (rsp_port.point_id),
      .split_axis  (rsp_port.split_axis),
      .end_of_tree (rsp_port.end_of_tree)
   );

   // never take a new item while a result waits
   `KDMB_ASSERT_NOW(a_no_overlap, clock, reset, req_port.ready, !rsp_port.valid)
   // after the last node leaves, loading resumes at once
   `KDMB_ASSERT_NEXT(a_resume, clock, reset,
                     rsp_port.valid && rsp_port.ready && rsp_port.end_of_tree, req_port.ready)
   // a final item ends loading
   `KDMB_ASSERT_NEXT(a_final_stops, clock, reset,
                     req_port.valid && req_port.ready && req_port.final_point, !req_port.ready)

endmodule

[tb/sv/tb_kdmb_ifs.sv]
`timescale 1ns / 100ps

// Interfaces are taken from the RTL (kdmb_req_if, kdmb_rsp_if); this file adds a passive
// observer used by the bench to count handshakes on the result channel.
module tb_rsp_observer import kdmb_pkg::*; (
   input logic        clock,
   kdmb_rsp_if.sink   mon,
   output int         handshakes
);
   int seen = 0;

   always @(posedge clock) begin
      if (mon.valid && mon.ready) seen <= seen + 1;
   end

   assign handshakes = seen;
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb import kdmb_pkg::*; ();

   localparam int MAX_PTS   = 64;
   localparam int LIMIT     = 3000000;
   localparam int DRAIN_CYC = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   kdmb_req_if req_ch ();
   kdmb_rsp_if rsp_ch ();

   kd_tree_median_build u_top (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_ch.sink),
      .rsp_port(rsp_ch.source)
   );

   int rsp_seen;
   tb_rsp_observer u_obs (.clock(clock), .mon(rsp_ch.sink), .handshakes(rsp_seen));

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   point_id;
      logic [AXIS_W-1:0] split_axis;
      logic              end_of_tree;
   } node_t;

   // predictor state: the points of the set being loaded, as order keys
   logic [31:0] key_x[MAX_PTS], key_y[MAX_PTS], key_z[MAX_PTS];
   logic [5:0]  perm[MAX_PTS];
   logic [1:0]  axis_of_slot[MAX_PTS];
   int          set_size;
   node_t       nodes_due[$];

   int errors, items_sent, nodes_checked, trees_built;
   int send_idle_pct, recv_idle_pct;
   bit hold_rsp;
   longint cycles;

   // flip the sign bit so that unsigned compare follows signed order
   function automatic logic [31:0] order_key(logic [31:0] v);
      return v ^ 32'h8000_0000;
   endfunction

   function automatic logic [31:0] key_at(int slot_i, int ax);
      int id;
      id = perm[slot_i];
      case (ax)
         0: return key_x[id];
         1: return key_y[id];
         default: return key_z[id];
      endcase
   endfunction

   function automatic void swap_perm(int a, int b);
      logic [5:0] t;
      t = perm[a]; perm[a] = perm[b]; perm[b] = t;
   endfunction

   // Lomuto partition with the middle element as pivot
   function automatic int partition_mid(int lo, int hi, int ax);
      int piv, st;
      logic [31:0] pv;
      piv = lo + (hi - lo) / 2;
      pv  = key_at(piv, ax);
      st  = lo;
      swap_perm(piv, hi - 1);
      for (int k = lo; k < hi - 1; k++) begin
         if (key_at(k, ax) < pv) begin
            swap_perm(k, st);
            st++;
         end
      end
      swap_perm(st, hi - 1);
      return st;
   endfunction

   function automatic void place_median(int lo, int nth, int hi, int ax);
      int p;
      while (hi - lo > 1) begin
         p = partition_mid(lo, hi, ax);
         if (p == nth) return;
         if (nth < p) hi = p;
         else lo = p + 1;
      end
   endfunction

   // build the balanced tree and queue one node per slot
   function automatic void predict_tree();
      int lo_s[$], hi_s[$], dp_s[$];
      int lo, hi, d, mid, ax;
      node_t nd;
      for (int i = 0; i < set_size; i++) perm[i] = i[5:0];
      lo_s.push_back(0); hi_s.push_back(set_size); dp_s.push_back(0);
      while (lo_s.size() > 0) begin
         lo = lo_s.pop_back(); hi = hi_s.pop_back(); d = dp_s.pop_back();
         if (lo >= hi) continue;
         ax  = d % 3;
         mid = lo + (hi - lo) / 2;
         place_median(lo, mid, hi, ax);
         axis_of_slot[mid] = ax[1:0];
         if (mid + 1 < hi) begin
            lo_s.push_back(mid + 1); hi_s.push_back(hi); dp_s.push_back(d + 1);
         end
         if (lo < mid) begin
            lo_s.push_back(lo); hi_s.push_back(mid); dp_s.push_back(d + 1);
         end
      end
      for (int i = 0; i < set_size; i++) begin
         nd.slot        = i[5:0];
         nd.point_id    = perm[i];
         nd.split_axis  = axis_of_slot[i];
         nd.end_of_tree = (i + 1 == set_size);
         nodes_due.push_back(nd);
      end
      set_size = 0;
      trees_built++;
   endfunction

   function automatic void absorb_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic fin);
      if (set_size < MAX_PTS) begin
         key_x[set_size] = order_key(x);
         key_y[set_size] = order_key(y);
         key_z[set_size] = order_key(z);
         set_size++;
      end
      if (fin) predict_tree();
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d (node %0d)", what, got, want,
               nodes_checked);
      errors++;
   endtask

   // offer one point and hold it until accepted
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic fin);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.x_coord     <= x;
      req_ch.y_coord     <= y;
      req_ch.z_coord     <= z;
      req_ch.final_point <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_point(x, y, z, fin);
      items_sent++;
   endtask

   task automatic go_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // pause until every queued node has arrived, then let the block settle
   task automatic wait_for_tree();
      go_quiet();
      while (nodes_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(7) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(int n, int style);
      logic [31:0] x, y, z;
      for (int i = 0; i < n; i++) begin
         x = rand_coord(); y = rand_coord(); z = rand_coord();
         if (style == 1) begin
            // heavy ties exercise the exact tie order
            x = $urandom_range(2); y = $urandom_range(1); z = 32'h0;
         end
         send_point(x, y, z, i == n - 1);
      end
   endtask

   // ---------------- named tests ----------------
   task automatic test_directed();
      // single point, then a pair
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1'b1);
      wait_for_tree();
      // equal keys on every axis
      for (int i = 0; i < 5; i++) send_point(32'h5, 32'h5, 32'h5, i == 4);
      // descending x, mixed signs
      for (int i = 0; i < 7; i++)
         send_point(32'd3 - i, 32'hFFFF_FFFF ^ i, i * 32'h1111_1111, i == 6);
      wait_for_tree();
   endtask

   task automatic test_overflow();
      // a full set plus extras: the extras are dropped, the final one still builds
      for (int i = 0; i < MAX_PTS + 3; i++)
         send_point($urandom, $urandom, $urandom, i == MAX_PTS + 2);
      wait_for_tree();
   endtask

   task automatic test_random(int points);
      int sent, n;
      sent = 0;
      while (sent < points) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
         send_set(n, $urandom_range(3) == 0);
         sent += n;
      end
   endtask

   task automatic test_backpressure();
      // hold the result channel while points keep coming, so input stalls
      hold_rsp = 1'b1;
      send_set(6, 0);
      send_set(4, 0);
      send_set(3, 1);
      hold_rsp = 1'b0;
      wait_for_tree();
   endtask

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_rsp) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // long hold-off counted in cycles of its own
   initial begin
      wait (hold_rsp);
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      node_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (nodes_due.size() == 0) begin
            report_mismatch("unexpected node slot", rsp_ch.slot, -1);
         end else begin
            want = nodes_due.pop_front();
            if (rsp_ch.slot !== want.slot)
               report_mismatch("slot", rsp_ch.slot, want.slot);
            if (rsp_ch.point_id !== want.point_id)
               report_mismatch("point_id", rsp_ch.point_id, want.point_id);
            if (rsp_ch.split_axis !== want.split_axis)
               report_mismatch("split_axis", rsp_ch.split_axis, want.split_axis);
            if (rsp_ch.end_of_tree !== want.end_of_tree)
               report_mismatch("end_of_tree", rsp_ch.end_of_tree, want.end_of_tree);
         end
         nodes_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int guard;
      cycles = 0; errors = 0; items_sent = 0; nodes_checked = 0; trees_built = 0;
      set_size = 0; hold_rsp = 1'b0; send_idle_pct = 18; recv_idle_pct = 54;
      req_ch.valid = 1'b0; req_ch.x_coord = '0; req_ch.y_coord = '0;
      req_ch.z_coord = '0; req_ch.final_point = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_random(35);
      wait_for_tree();
      send_idle_pct = 54; recv_idle_pct = 18;
      test_random(35);
      wait_for_tree();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(30);
      test_backpressure();

      // drain: nothing outstanding, then a short settle
      go_quiet();
      guard = 0;
      while (nodes_due.size() > 0 && guard < 500000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYC) @(posedge clock);
      if (nodes_due.size() > 0) begin
         report_mismatch("nodes outstanding", nodes_due.size(), 0);
      end
      $display("Covered %0d points in %0d trees, %0d nodes checked (%0d handshakes).",
               items_sent, trees_built, nodes_checked, rsp_seen);
      $display("Included extreme coordinates, ties, set overflow and result back-pressure.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

[kd_tree_median_build.f]
+incdir+sv
sv/kdmb_pkg.sv
sv/kdmb_ifs.sv
sv/kdmb_ctrl.sv
sv/kdmb_dpath.sv
sv/kd_tree_median_build.sv
tb/sv/tb_kdmb_ifs.sv
tb/sv/tb.sv
